### rtl/core/b58_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the character map for the base58 encoder.
// No dependencies.
package b58_pkg;

    localparam int unsigned RESULT_CAP = 55;
    localparam int unsigned RADIX      = 58;
    localparam int unsigned RECIP      = 18079;  // ceil(2^20 / 58)
    localparam int unsigned RECIP_SH   = 20;
    localparam logic [7:0]  CHAR_ONE   = 8'h31;  // '1'
    localparam logic [6:0]  MOX_RESET  = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } enc_state_t;

    // Map one base58 digit to its ASCII character.
    function automatic logic [7:0] b58_char(input logic [5:0] d);
        logic [7:0] dd;
        logic [7:0] c;
        dd = {2'b00, d};
        if (d < 6'd9)
            c = 8'h31 + dd;                 // 1..9
        else if (d < 6'd17)
            c = 8'h41 + (dd - 8'd9);        // A..H
        else if (d < 6'd22)
            c = 8'h4A + (dd - 8'd17);       // J..N
        else if (d < 6'd33)
            c = 8'h50 + (dd - 8'd22);       // P..Z
        else if (d < 6'd44)
            c = 8'h61 + (dd - 8'd33);       // a..k
        else if (d < 6'd58)
            c = 8'h6D + (dd - 8'd44);       // m..z
        else
            c = 8'h00;
        return c;
    endfunction

endpackage

### rtl/core/base58_encoder.sv
`timescale 1ns / 1ps
// Base58 (Bitcoin alphabet) encoder: top level with control and APB register.
// Depends on b58_pkg, b58_div58, b58_byte_cell, b58_digit_cell.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------
//  input     | start, busy             | data_byte, last_byte
//  result    | result_valid (1 cycle)  | symbol, last_symbol, too_long
//  register  | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// A byte that is not the last one leaves busy low.
// On the last byte of an n-byte message the ring of byte cells rotates once
// per cycle through the single divide-by-58 step; each full turn of n bytes
// gives one digit, and then the characters are emitted at one per cycle.
// rst_n clears all control state and sets max_out_chars to 64; the byte and
// digit cells are not reset. Results cannot be stalled: each transaction on
// the result side is shown for exactly one cycle.
module base58_encoder #(
    parameter int MAX_BYTES  = 36,
    parameter int MAX_DIGITS = 50
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // results
    output logic        result_valid,
    output logic [7:0]  symbol,
    output logic        last_symbol,
    output logic        too_long,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b58_pkg::*;

    localparam int BCW = $clog2(MAX_BYTES + 1);
    localparam int DCW = $clog2(MAX_DIGITS + 1);
    localparam int TW  = ((BCW > DCW) ? BCW : DCW) + 1;
    localparam int CW  = (TW > 7) ? TW : 7;

    enc_state_t     state_reg, state_next;
    logic [BCW-1:0] byte_count_reg, byte_count_next;
    logic           overflow_reg, overflow_next;
    logic [BCW-1:0] lzc_reg, lzc_next;
    logic           nz_seen_reg, nz_seen_next;
    logic [DCW-1:0] dcount_reg, dcount_next;
    logic [BCW-1:0] pos_reg, pos_next;
    logic [5:0]     rem_reg, rem_next;
    logic           pass_nz_reg, pass_nz_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [6:0]     mox_reg;

    logic           valid_reg, valid_next;
    logic [7:0]     symbol_reg, symbol_next;
    logic           last_reg, last_next;
    logic           err_reg, err_next;

    logic           accept;
    logic           div_shift;
    logic           push;
    logic           pop;
    logic           pass_end;
    logic           byte_nz;
    logic [7:0]     head_byte;
    logic [7:0]     quo;
    logic [5:0]     rem_out;
    logic [7:0]     byte_q   [MAX_BYTES];
    logic [5:0]     digit_q  [MAX_DIGITS];
    logic [CW-1:0]  mox_eff;
    logic [CW-1:0]  total;
    logic [CW-1:0]  lim;
    logic [CW-1:0]  lim_a;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign byte_nz = (data_byte != 8'd0);

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, mox_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mox_reg <= MOX_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            mox_reg <= pwdata[6:0];
    end

    // ---------------- ring of byte cells ----------------
    assign head_byte = byte_q[0];
    assign div_shift = (state_reg == S_DIV);

    b58_div58 u_div
    (
        .rem_in  (rem_reg),
        .byte_in (head_byte),
        .quo     (quo),
        .rem_out (rem_out)
    );

    for (genvar i = 0; i < MAX_BYTES; i++)
    begin : g_byte
        logic [7:0] right_byte;
        if (i == MAX_BYTES - 1)
        begin : g_end
            assign right_byte = byte_q[i];
        end
        else
        begin : g_mid
            assign right_byte = byte_q[i + 1];
        end

        b58_byte_cell u_cell
        (
            .clk        (clk),
            .load       (accept && (byte_count_reg == BCW'(i))),
            .shift      (div_shift),
            .is_tail    (byte_count_reg == BCW'(i + 1)),
            .load_byte  (data_byte),
            .right_byte (right_byte),
            .fb_byte    (quo),
            .cell_byte  (byte_q[i])
        );
    end

    // ---------------- digit stack ----------------
    assign pass_end = div_shift && (pos_reg == byte_count_reg - BCW'(1));
    assign push     = pass_end && (dcount_reg < DCW'(MAX_DIGITS));
    assign pop      = (state_reg == S_EMIT) && (k_reg >= CW'(lzc_reg));

    for (genvar j = 0; j < MAX_DIGITS; j++)
    begin : g_digit
        logic [5:0] push_in;
        logic [5:0] pop_in;
        if (j == 0)
        begin : g_top
            assign push_in = rem_out;
        end
        else
        begin : g_below
            assign push_in = digit_q[j - 1];
        end
        if (j == MAX_DIGITS - 1)
        begin : g_bottom
            assign pop_in = digit_q[j];
        end
        else
        begin : g_above
            assign pop_in = digit_q[j + 1];
        end

        b58_digit_cell u_cell
        (
            .clk     (clk),
            .push    (push),
            .pop     (pop),
            .push_in (push_in),
            .pop_in  (pop_in),
            .digit   (digit_q[j])
        );
    end

    // ---------------- emit length ----------------
    // A zero count register still emits one character; cap at the result limit
    assign mox_eff = (mox_reg == 7'd0) ? CW'(1) : CW'(mox_reg);
    assign total   = CW'(lzc_reg) + CW'(dcount_reg);
    assign lim_a   = (mox_eff < total) ? mox_eff : total;
    assign lim     = (lim_a < CW'(RESULT_CAP)) ? lim_a : CW'(RESULT_CAP);

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        overflow_next   = overflow_reg;
        lzc_next        = lzc_reg;
        nz_seen_next    = nz_seen_reg;
        dcount_next     = dcount_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        pass_nz_next    = pass_nz_reg;
        k_next          = k_reg;
        valid_next      = 1'b0;
        symbol_next     = symbol_reg;
        last_next       = last_reg;
        err_next        = err_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_count_reg < BCW'(MAX_BYTES))
                    begin
                        byte_count_next = byte_count_reg + BCW'(1);
                        if (!nz_seen_reg && !byte_nz)
                            lzc_next = lzc_reg + BCW'(1);
                        if (byte_nz)
                            nz_seen_next = 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end

                    if (last_byte)
                    begin
                        if (overflow_next)
                        begin
                            // single error result, drop the message
                            valid_next      = 1'b1;
                            symbol_next     = 8'd0;
                            last_next       = 1'b1;
                            err_next        = 1'b1;
                            byte_count_next = '0;
                            overflow_next   = 1'b0;
                            lzc_next        = '0;
                            nz_seen_next    = 1'b0;
                            dcount_next     = '0;
                        end
                        else if (nz_seen_next)
                        begin
                            state_next   = S_DIV;
                            pos_next     = '0;
                            rem_next     = '0;
                            pass_nz_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                            k_next     = '0;
                        end
                    end
                end
            end

            S_DIV:
            begin
                if (pass_end)
                begin
                    // remainder is the next digit; stop once the quotient is zero
                    if (push)
                        dcount_next = dcount_reg + DCW'(1);
                    pos_next     = '0;
                    rem_next     = '0;
                    pass_nz_next = 1'b0;
                    if (!(pass_nz_reg || (quo != 8'd0)))
                    begin
                        state_next = S_EMIT;
                        k_next     = '0;
                    end
                end
                else
                begin
                    pos_next     = pos_reg + BCW'(1);
                    rem_next     = rem_out;
                    pass_nz_next = pass_nz_reg || (quo != 8'd0);
                end
            end

            S_EMIT:
            begin
                valid_next  = 1'b1;
                err_next    = 1'b0;
                symbol_next = pop ? b58_char(digit_q[0]) : CHAR_ONE;
                last_next   = ((k_reg + CW'(1)) == lim);
                if (last_next)
                begin
                    state_next      = S_IDLE;
                    byte_count_next = '0;
                    overflow_next   = 1'b0;
                    lzc_next        = '0;
                    nz_seen_next    = 1'b0;
                    dcount_next     = '0;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            lzc_reg        <= '0;
            nz_seen_reg    <= 1'b0;
            dcount_reg     <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            pass_nz_reg    <= 1'b0;
            k_reg          <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
            lzc_reg        <= lzc_next;
            nz_seen_reg    <= nz_seen_next;
            dcount_reg     <= dcount_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            pass_nz_reg    <= pass_nz_next;
            k_reg          <= k_next;
            valid_reg      <= valid_next;
        end
    end

    // result payload holds between strobes
    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

    assign result_valid = valid_reg;
    assign symbol       = symbol_reg;
    assign last_symbol  = last_reg;
    assign too_long     = err_reg;

endmodule

### rtl/core/b58_div58.sv
`timescale 1ns / 1ps
// One long-division step by 58: {remainder, byte} -> quotient byte, remainder.
// Depends on b58_pkg.
module b58_div58
(
    input  logic [5:0] rem_in,
    input  logic [7:0] byte_in,
    output logic [7:0] quo,
    output logic [5:0] rem_out
);
    import b58_pkg::*;

    logic [13:0] dividend;
    logic [34:0] prod;
    logic [13:0] back;

    assign dividend = {rem_in, byte_in};
    // Reciprocal is exact for every dividend below 58 * 256
    assign prod     = 35'(dividend) * 35'(RECIP);
    assign quo      = prod[RECIP_SH +: 8];
    assign back     = 14'(quo) * 14'(RADIX);
    assign rem_out  = 6'(dividend - back);

endmodule

### rtl/core/b58_byte_cell.sv
`timescale 1ns / 1ps
// One byte of the number under division; shifts towards the head each step.
// No dependencies.
module b58_byte_cell
(
    input  logic       clk,
    input  logic       load,
    input  logic       shift,
    input  logic       is_tail,
    input  logic [7:0] load_byte,
    input  logic [7:0] right_byte,
    input  logic [7:0] fb_byte,
    output logic [7:0] cell_byte
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (load)
            byte_next = load_byte;
        else if (shift)
            byte_next = is_tail ? fb_byte : right_byte;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

### rtl/core/b58_digit_cell.sv
`timescale 1ns / 1ps
// One slot of the digit stack; push moves away from the top, pop towards it.
// No dependencies.
module b58_digit_cell
(
    input  logic       clk,
    input  logic       push,
    input  logic       pop,
    input  logic [5:0] push_in,
    input  logic [5:0] pop_in,
    output logic [5:0] digit
);
    logic [5:0] digit_reg;
    logic [5:0] digit_next;

    always_comb
    begin
        digit_next = digit_reg;
        if (push)
            digit_next = push_in;
        else if (pop)
            digit_next = pop_in;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for base58_encoder: byte messages in, base58 characters out.
// Depends on b58_pkg and the base58_encoder RTL; needs no other file.
module tb_top;
    import b58_pkg::*;

    // Block sizes; keep these in step with the instance parameters below.
    localparam int MAX_BYTES     = 36;
    localparam int MAX_DIGITS    = 50;
    localparam int CHAR_CAP      = 55;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 50;        // each phase runs past this by a message
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 12;

    localparam logic [2:0] ADDR_MAX_OUT_CHARS = 3'd0;
    localparam logic [6:0] LIMIT_AT_RESET     = 7'd64;

    // Digit d sits at byte (57 - d) of this vector.
    localparam logic [8*58-1:0] DIGIT_CHARS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
        logic       too_long;
    } b58_char_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;      // want holds the single expected character
        logic [7:0] want;
    } stim_row_t;

    typedef enum int {
        MSG_SHORT,
        MSG_LEAD_ZERO,
        MSG_ALL_ZERO,
        MSG_ALL_ONES,
        MSG_FULL,
        MSG_OVERLONG,
        MSG_MIXED
    } msg_kind_t;

    localparam int NUM_KINDS = 7;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;

    logic        busy;
    logic        result_valid;
    logic [7:0]  symbol;
    logic        last_symbol;
    logic        too_long;
    logic [31:0] prdata;
    logic        pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    base58_encoder #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_DIGITS (MAX_DIGITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .too_long     (too_long),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Encoder predictor: its own copy of the message and the char limit
    // ------------------------------------------------------------------
    logic [7:0]  msg_bytes [MAX_BYTES];
    int unsigned msg_len      = 0;
    bit          msg_overflow = 1'b0;
    logic [6:0]  char_limit   = LIMIT_AT_RESET;

    b58_char_t   fresh_chars [$];    // characters caused by the latest transaction
    b58_char_t   pending_chars [$];  // characters still owed by the block

    int          errors      = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          steady      = 1'b0; // no gaps between transactions while set

    // Take one byte into the message; on the last byte work out the encoding.
    function automatic void predict_byte(input logic [7:0] b, input logic l);
        logic [7:0]  work [MAX_BYTES];
        int unsigned digits [$];
        int unsigned zeros, head, rem, v, total, lim, d, k, i;
        fresh_chars.delete();
        if (msg_len < MAX_BYTES)
        begin
            msg_bytes[msg_len] = b;
            msg_len++;
        end
        else
            msg_overflow = 1'b1;
        if (!l)
            return;
        if (msg_overflow)
            fresh_chars.push_back('{8'h00, 1'b1, 1'b1});
        else
        begin
            work  = msg_bytes;
            zeros = 0;
            while (zeros < msg_len && work[zeros] == 8'h00)
                zeros++;
            // Long division by 58, least significant digit first; skip the
            // quotient's leading zeros as they appear.
            head = zeros;
            while (head < msg_len)
            begin
                rem = 0;
                for (i = head; i < msg_len; i++)
                begin
                    v       = rem * 256 + work[i];
                    work[i] = 8'(v / 58);
                    rem     = v % 58;
                end
                if (digits.size() < MAX_DIGITS)
                    digits.push_back(rem);
                while (head < msg_len && work[head] == 8'h00)
                    head++;
            end
            total = zeros + digits.size();
            lim   = (char_limit == 7'd0) ? 1 : char_limit;
            if (lim > total)
                lim = total;
            if (lim > CHAR_CAP)
                lim = CHAR_CAP;
            for (k = 0; k < lim; k++)
            begin
                d = (k < zeros) ? 0 : digits[digits.size() - 1 - (k - zeros)];
                fresh_chars.push_back('{DIGIT_CHARS[8*(57-d) +: 8], (k + 1 == lim), 1'b0});
            end
        end
        msg_len      = 0;
        msg_overflow = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe is one transaction, matched in order
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        b58_char_t want;
        if (rst_n && result_valid)
        begin
            if (pending_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: symbol %h last_symbol %b too_long %b",
                         $time, symbol, last_symbol, too_long);
            end
            else
            begin
                want = pending_chars.pop_front();
                if (symbol !== want.symbol)
                begin
                    errors++;
                    $display("%0t: symbol mismatch: expected %h actual %h",
                             $time, want.symbol, symbol);
                end
                if (last_symbol !== want.last_symbol)
                begin
                    errors++;
                    $display("%0t: last_symbol mismatch: expected %b actual %b",
                             $time, want.last_symbol, last_symbol);
                end
                if (too_long !== want.too_long)
                begin
                    errors++;
                    $display("%0t: too_long mismatch: expected %b actual %b",
                             $time, want.too_long, too_long);
                end
            end
        end
    end

    // Watchdog: drop out if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d characters owed", $time,
                     pending_chars.size());
            $display("FAIL base58_encoder");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------

    // Offer one byte after a random gap and hold it until the block takes it.
    // Leave start high on return so a back-to-back byte needs one assignment only.
    task automatic send_item(input logic [7:0] b, input logic l);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        send_item(b, l);
        predict_byte(b, l);
        foreach (fresh_chars[i])
            pending_chars.push_back(fresh_chars[i]);
    endtask

    // Drop start, then hold until every owed character is out and the block
    // has settled: a non-final byte causes no result but may still be in flight.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_chars.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write max_out_chars over the register port, then read it back.
    task automatic write_limit(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_OUT_CHARS;
        pwdata  <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        char_limit = value;
        // Keep psel high and go straight into the read setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[6:0] !== value)
        begin
            errors++;
            $display("%0t: max_out_chars readback mismatch: expected %h actual %h",
                     $time, value, prdata[6:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One message of the given kind; extreme: max-length zeros/ones, overlong by one byte.
    task automatic send_message(input msg_kind_t kind, input bit extreme);
        int         len, lead, i;
        logic [7:0] b;
        steady = ($urandom_range(0, 3) == 0);
        lead   = 0;
        case (kind)
            MSG_SHORT:     len = $urandom_range(1, 8);
            MSG_LEAD_ZERO:
            begin
                len  = $urandom_range(2, 12);
                lead = $urandom_range(1, len - 1);
            end
            MSG_ALL_ZERO:  len = extreme ? MAX_BYTES : $urandom_range(1, 10);
            MSG_ALL_ONES:  len = extreme ? MAX_BYTES : $urandom_range(1, 12);
            MSG_FULL:      len = MAX_BYTES;
            MSG_OVERLONG:  len = extreme ? MAX_BYTES + 1 : $urandom_range(MAX_BYTES + 1, 44);
            default:       len = $urandom_range(1, 20);
        endcase
        for (i = 0; i < len; i++)
        begin
            case (kind)
                MSG_ALL_ZERO:  b = 8'h00;
                MSG_ALL_ONES:  b = 8'hff;
                MSG_LEAD_ZERO: b = (i < lead) ? 8'h00 : 8'($urandom_range(0, 255));
                MSG_MIXED:
                    case ($urandom_range(0, 3))
                        0:       b = 8'h00;
                        1:       b = 8'hff;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                default:       b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table: extremes of the byte, leading and interior zeros,
    // all-zero messages and the largest single-byte digit
    // ------------------------------------------------------------------
    stim_row_t directed_rows [24] = '{
        '{8'h00, 1'b1, 1'b1, 8'h31},   // lone zero byte gives '1'
        '{8'h01, 1'b1, 1'b1, 8'h32},   // smallest non-zero value gives '2'
        '{8'h39, 1'b1, 1'b1, 8'h7a},   // 57, highest single digit, gives 'z'
        '{8'h3a, 1'b1, 1'b0, 8'h00},   // 58 needs two digits
        '{8'hff, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},   // all-zero message: one '1' per byte
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},   // leading zero then a value
        '{8'hff, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'hff, 1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b1, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},   // interior zeros must not be skipped
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h3a, 1'b1, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b0, 8'h00},
        '{8'haa, 1'b1, 1'b0, 8'h00}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        logic [6:0] plan [NUM_PHASES];
        msg_kind_t  kind;
        int         phase, phase_start, msg_index, pick;

        // Hold reset, then release it on a clock edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit of 64; back-to-back first, then with gaps.
        foreach (directed_rows[r])
        begin
            steady = (r < 12);
            send_item(directed_rows[r].data, directed_rows[r].last);
            predict_byte(directed_rows[r].data, directed_rows[r].last);
            if (directed_rows[r].typed)
                pending_chars.push_back('{directed_rows[r].want, 1'b1, 1'b0});
            else
                foreach (fresh_chars[i])
                    pending_chars.push_back(fresh_chars[i]);
        end

        // Limit settings: the smallest, zero (acts as 1), the register maximum,
        // the reset value, two random ones, then 3.
        plan[0] = 7'd1;
        plan[1] = 7'd0;
        plan[2] = 7'd127;
        plan[3] = 7'd64;
        plan[4] = 7'($urandom_range(2, 12));
        plan[5] = 7'($urandom_range(1, 64));
        plan[6] = 7'd3;

        msg_index = 0;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            write_limit(plan[phase]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // Walk every message kind once at its extreme, then draw at random.
                if (msg_index < NUM_KINDS)
                    kind = msg_kind_t'(msg_index);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        kind = MSG_SHORT;
                    else if (pick < 55)
                        kind = MSG_LEAD_ZERO;
                    else if (pick < 62)
                        kind = MSG_ALL_ZERO;
                    else if (pick < 72)
                        kind = MSG_ALL_ONES;
                    else if (pick < 77)
                        kind = MSG_FULL;
                    else if (pick < 82)
                        kind = MSG_OVERLONG;
                    else
                        kind = MSG_MIXED;
                end
                send_message(kind, msg_index < NUM_KINDS || $urandom_range(0, 15) == 0);
                msg_index++;
                // Now and then pause until the block has delivered everything.
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (errors == 0)
            $display("PASS base58_encoder");
        else
            $display("FAIL base58_encoder");
        $finish;
    end

endmodule
